// ===== sv/lqr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_pkg
// Shared widths, command and status codes, and the controller/datapath
// command and status bundles of the linear queue with reverse.
// ----------------------------------------------------------------------------
package lqr_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REV = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              enq;          // append a word at the tail
    logic              enq_stack;    // appended word comes from the stack read port
    logic              deq;          // read head slot, advance head
    logic              spush;        // push the queue read data onto the stack
    logic              spop;         // read top of stack, drop it
    logic              out_load;     // load the result register
    logic [STAT_W-1:0] out_status;
    logic              out_mem;      // result data from the queue read port
  } lqr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic tail_last;
    logic stack_zero;
    logic out_busy;
  } lqr_stat_t;

endpackage
`default_nettype wire

// ===== sv/lqr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_in_if / lqr_out_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface lqr_in_if
  import lqr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [WORD_W-1:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface lqr_out_if
  import lqr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface
`default_nettype wire

// ===== sv/linear_queue_with_reverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_queue_with_reverse
// Linear (non-circular) queue of signed 32-bit words with a reverse command.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command per transfer: enqueue (with data_in),
//   dequeue or reverse. out_chan returns exactly one result per command:
//   status (ok, overflow, underflow) and data_out (dequeued word, else zero).
//   Enqueue, dequeue on an empty queue and unused codes finish in the
//   transfer cycle; the result is valid on the next cycle. A dequeue that
//   returns a word first waits in S_DEQ for one store read.
//   Reverse moves each word from the store onto the stack (S_TAKE,
//   S_PUSH), then puts each back (S_POP, S_PUT); its result is
//   presented right away while the walk runs, and no new command is taken
//   until the walk is done.
//   Enqueue sustains one command per cycle while out_chan.ready is high; a
//   dequeue that returns a word holds off the next command for its store read.
//   A result waits in the output register while out_chan.ready is low; one
//   more command is taken as that result transfers.
//   Reset (rst_n low, synchronous) empties the queue and the stack and
//   drops any pending result.
// ----------------------------------------------------------------------------
module linear_queue_with_reverse
  import lqr_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lqr_in_if.sink     in_chan,
  lqr_out_if.source  out_chan
);

  lqr_cmd_t          cmd;
  lqr_stat_t         stat;
  logic [WORD_W-1:0] out_word;

  lqr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_ready  (out_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lqr_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_word    (in_chan.data_in),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_status (out_chan.status),
    .out_word   (out_word)
  );

  assign out_chan.data_out = signed'(out_word);

endmodule
`default_nettype wire

// ===== sv/lqr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lqr_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/lqr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_dp
// Queue datapath: queue store, reversal stack, head/tail/empty, stack count
// and the result register.
// ----------------------------------------------------------------------------
module lqr_dp
  import lqr_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lqr_cmd_t                 cmd,
  output      lqr_stat_t                stat,
  input  wire logic [WORD_W-1:0]        in_word,
  input  wire logic                     out_ready,
  output      logic                     out_valid,
  output      logic [STAT_W-1:0]        out_status,
  output      logic [WORD_W-1:0]        out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic              empty_r, empty_nxt;
  logic [CW-1:0]     sp_r, sp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [WORD_W-1:0] out_word_r;

  logic              q_we;
  logic [AW-1:0]     q_waddr;
  logic [WORD_W-1:0] q_wdata;
  logic [WORD_W-1:0] q_rdata;
  logic [AW-1:0]     s_raddr;
  logic [WORD_W-1:0] s_rdata;
  logic [CW-1:0]     sp_dec;

  assign sp_dec  = sp_r - CW'(1);
  assign s_raddr = sp_dec[AW-1:0];

  // enqueue into an empty queue restarts at slot zero
  assign q_we    = cmd.enq;
  assign q_waddr = empty_r ? '0 : tail_r + AW'(1);
  assign q_wdata = cmd.enq_stack ? s_rdata : in_word;

  lqr_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  lqr_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.spush),
    .waddr (sp_r[AW-1:0]),
    .wdata (q_rdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    sp_nxt    = sp_r;
    if (cmd.enq) begin
      if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else begin
        tail_nxt = tail_r + AW'(1);
      end
    end
    if (cmd.deq) begin
      if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else begin
        head_nxt = head_r + AW'(1);
      end
    end
    if (cmd.spush) begin
      sp_nxt = sp_r + CW'(1);
    end
    if (cmd.spop) begin
      sp_nxt = sp_dec;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_word_r   <= cmd.out_mem ? q_rdata : '0;
    end
  end

  assign stat.empty      = empty_r;
  assign stat.tail_last  = (tail_r == LAST);
  assign stat.stack_zero = (sp_r == '0);
  assign stat.out_busy   = out_valid_r;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_word   = out_word_r;

endmodule
`default_nettype wire

// ===== sv/lqr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_ctrl
// Command sequencer: decodes accepted commands, waits out the store read
// latency and walks the queue through the stack for a reverse.
// ----------------------------------------------------------------------------
module lqr_ctrl
  import lqr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output      logic             in_ready,
  input  wire logic             out_ready,
  input  wire lqr_stat_t        stat,
  output      lqr_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DEQ    = 6'b000010,
    S_TAKE   = 6'b000100,
    S_PUSH   = 6'b001000,
    S_POP    = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // one command in flight; result register must be free or draining
  assign in_ready = (state_r == S_IDLE) && (!stat.out_busy || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          unique case (in_command)
            CMD_ENQ: begin
              if (!stat.empty && stat.tail_last) begin
                cmd.out_status = ST_OVER;
              end else begin
                cmd.enq = 1'b1;
              end
            end
            CMD_DEQ: begin
              if (stat.empty) begin
                cmd.out_status = ST_UNDER;
              end else begin
                // result loads once the head word is read back
                cmd.out_load = 1'b0;
                cmd.deq      = 1'b1;
                state_nxt    = S_DEQ;
              end
            end
            CMD_REV: begin
              if (!stat.empty) begin
                state_nxt = S_TAKE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = ST_OK;
        cmd.out_mem    = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_TAKE: begin
        cmd.deq   = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.spush = 1'b1;
        state_nxt = stat.empty ? S_POP : S_TAKE;
      end
      S_POP: begin
        cmd.spop  = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.enq       = 1'b1;
        cmd.enq_stack = 1'b1;
        state_nxt     = stat.stack_zero ? S_IDLE : S_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== verif/linear_queue_with_reverse_tb.sv =====
// ----------------------------------------------------------------------------
// linear_queue_with_reverse_tb
// Drives enqueue, dequeue, reverse and unused command codes into the queue
// and checks every result, in order, against a queue mirror kept by the
// bench. Both channels get random idle bursts, one long output hold-off and
// drain pauses. The last phase runs with no idling.
// ----------------------------------------------------------------------------
module linear_queue_with_reverse_tb;
  import lqr_pkg::*;

  localparam int QDEPTH         = 32;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_WAIT       = 150;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] word;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lqr_in_if  in_if ();
  lqr_out_if out_if ();

  linear_queue_with_reverse #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always #10 clk = ~clk;

  // mirror of the queue contents, updated at each input transfer
  logic [WORD_W-1:0] q_store [QDEPTH];
  int                q_head  = 0;
  int                q_tail  = 0;
  bit                q_empty = 1'b1;

  queue_result_t results_due[$];
  int            mismatches    = 0;
  int            quiet_cycles  = 0;
  bit            src_idle_en   = 1'b0;
  bit            sink_idle_en  = 1'b0;
  bit            long_hold_req = 1'b0;

  function automatic void predict_queue_op(input logic [CMD_W-1:0] cmd,
                                           input logic [WORD_W-1:0] word);
    queue_result_t     r;
    logic [WORD_W-1:0] stacked[$];
    r.status = ST_OK;
    r.word   = '0;
    case (cmd)
      CMD_ENQ: begin
        if (q_empty) begin
          q_head     = 0;
          q_tail     = 0;
          q_store[0] = word;
          q_empty    = 1'b0;
        end else if (q_tail == QDEPTH - 1) begin
          r.status = ST_OVER;
        end else begin
          q_tail++;
          q_store[q_tail] = word;
        end
      end
      CMD_DEQ: begin
        if (q_empty) begin
          r.status = ST_UNDER;
        end else begin
          r.word = q_store[q_head];
          if (q_head == q_tail) begin
            q_empty = 1'b1;
            q_head  = 0;
            q_tail  = 0;
          end else begin
            q_head++;
          end
        end
      end
      CMD_REV: begin
        if (!q_empty) begin
          for (int i = q_head; i <= q_tail; i++) stacked.push_front(q_store[i]);
          foreach (stacked[i]) q_store[i] = stacked[i];
          q_head = 0;
          q_tail = stacked.size() - 1;
        end
      end
      default: ;
    endcase
    results_due.push_back(r);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int enq_pct, input int deq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return CMD_ENQ;
    if (r < enq_pct + deq_pct) return CMD_DEQ;
    if (r < 98) return CMD_REV;
    return CMD_NOP;
  endfunction

  // one command transfer; the mirror is updated at the accepting edge
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.data_in <= word;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_queue_op(cmd, word);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_cmd(CMD_DEQ, pick_word());   // underflow on empty
    send_cmd(CMD_REV, pick_word());   // reverse of empty queue
    send_cmd(CMD_NOP, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQ, 32'h8000_0000);
    send_cmd(CMD_ENQ, 32'h7FFF_FFFF);
    send_cmd(CMD_ENQ, 32'h0000_0000);
    send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
    send_cmd(CMD_REV, 32'h0000_0000);
    repeat (4) send_cmd(CMD_DEQ, 32'hFFFF_FFFF);
    send_cmd(CMD_DEQ, 32'h0000_0000);
    // single word: reverse is a no-op, then head and tail go back to zero
    send_cmd(CMD_ENQ, 32'h0000_0001);
    send_cmd(CMD_REV, pick_word());
    send_cmd(CMD_DEQ, pick_word());
    send_cmd(CMD_ENQ, 32'hA5A5_5A5A);
    send_cmd(CMD_DEQ, pick_word());
  endtask

  task automatic test_full_queue();
    while (!q_empty) send_cmd(CMD_DEQ, pick_word());
    repeat (QDEPTH) send_cmd(CMD_ENQ, pick_word());
    send_cmd(CMD_ENQ, pick_word());            // overflow
    repeat (3) send_cmd(CMD_DEQ, pick_word());
    send_cmd(CMD_ENQ, pick_word());            // still overflow, front slots unused
    send_cmd(CMD_REV, pick_word());            // compacts to slots 0..n-1
    send_cmd(CMD_ENQ, pick_word());
    send_cmd(CMD_REV, pick_word());
    while (!q_empty) send_cmd(CMD_DEQ, pick_word());
    send_cmd(CMD_DEQ, pick_word());
  endtask

  task automatic test_backpressure();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_cmd(pick_cmd(70, 25), pick_word());
    wait_results_drained();
  endtask

  task automatic test_random_mix(input int n_items);
    int sent;
    int enq_pct;
    int deq_pct;
    int chunk;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0:       begin enq_pct = 72; deq_pct = 22; end
        1:       begin enq_pct = 25; deq_pct = 70; end
        default: begin enq_pct = 48; deq_pct = 46; end
      endcase
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      chunk = $urandom_range(20, 60);
      repeat (chunk) send_cmd(pick_cmd(enq_pct, deq_pct), pick_word());
      sent += chunk;
      if ($urandom_range(0, 5) == 0) wait_results_drained();
    end
  endtask

  task automatic test_streaming(input int n_items);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (n_items) send_cmd(pick_cmd(50, 45), pick_word());
  endtask

  initial begin : sink_side
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    queue_result_t due;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d data_out=%0d",
                 $time, out_if.status, out_if.data_out);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        if (out_if.status !== due.status) begin
          $display("%0t: status expected %0d got %0d", $time, due.status, out_if.status);
          mismatches++;
        end
        if (out_if.data_out !== due.word) begin
          $display("%0t: data_out expected %0d got %0d", $time, due.word, out_if.data_out);
          mismatches++;
        end
      end
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : run
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_ENQ;
    in_if.data_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_full_queue();
    test_backpressure();
    test_random_mix(1600);
    test_streaming(220);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
